### rtl/pmid_pkg.sv
// Shared types and constants for the periodic minimum-image distance block.
// Depends on nothing; used by every module under rtl.
package pmid_pkg;

  // Coordinate and lattice formats
  localparam int COORD_BITS = 21;
  localparam int LAT_BITS   = 63;
  localparam int DIMS_BITS  = 2;

  // Difference, image offset and distance widths
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int IMG_BITS   = COORD_BITS + 3;
  localparam int OUT_BITS   = 22;
  localparam int SQ_BITS    = 2 * OUT_BITS;
  localparam int KEY_BITS   = SQ_BITS + 2;
  localparam int REM_BITS   = SQ_BITS + 1;

  // Image count and square root steps
  localparam int IMAGES     = 27;
  localparam int ROOT_STEPS = OUT_BITS;

  // Register map (byte address / 8)
  localparam logic [1:0] REG_DIMS = 2'd0;
  localparam logic [1:0] REG_A1   = 2'd1;
  localparam logic [1:0] REG_A2   = 2'd2;
  localparam logic [1:0] REG_A3   = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic        [OUT_BITS-1:0]   dist_t;
  typedef logic        [KEY_BITS-1:0]   key_t;
  typedef logic        [LAT_BITS-1:0]   lat_t;

  // Request traveling down the pipeline with its key
  typedef struct packed {
    logic valid;
    key_t key;
  } keyreq_t;

endpackage

### rtl/pmid_image.sv
// Image stages: coordinate difference, 27 image offsets, squares, sums.
// Depends on pmid_pkg.
module pmid_image (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  pmid_pkg::coord_t             first_x,
  input  pmid_pkg::coord_t             first_y,
  input  pmid_pkg::coord_t             first_z,
  input  pmid_pkg::coord_t             second_x,
  input  pmid_pkg::coord_t             second_y,
  input  pmid_pkg::coord_t             second_z,
  input  logic [pmid_pkg::DIMS_BITS-1:0] dims,
  input  pmid_pkg::lat_t               a1,
  input  pmid_pkg::lat_t               a2,
  input  pmid_pkg::lat_t               a3,
  output logic                         out_valid,
  output pmid_pkg::key_t               keys [pmid_pkg::IMAGES]
);

  localparam int CB = pmid_pkg::COORD_BITS;
  localparam int IB = pmid_pkg::IMG_BITS;
  localparam int OB = pmid_pkg::OUT_BITS;
  localparam int SB = pmid_pkg::SQ_BITS;
  localparam int KB = pmid_pkg::KEY_BITS;
  localparam int N  = pmid_pkg::IMAGES;

  logic                 v1, v2, v3;
  pmid_pkg::diff_t      base [3];
  logic [OB-1:0]        ad   [N][3];
  logic                 ok2  [N];
  logic [SB-1:0]        sq   [N][3];
  logic                 ok3  [N];
  logic signed [IB-1:0] la1  [3];
  logic signed [IB-1:0] la2  [3];
  logic signed [IB-1:0] la3  [3];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // Take the difference second minus first
  always_ff @(posedge clk) begin
    base[0] <= pmid_pkg::DIFF_BITS'(second_x) - pmid_pkg::DIFF_BITS'(first_x);
    base[1] <= pmid_pkg::DIFF_BITS'(second_y) - pmid_pkg::DIFF_BITS'(first_y);
    base[2] <= pmid_pkg::DIFF_BITS'(second_z) - pmid_pkg::DIFF_BITS'(first_z);
  end

  // Unpack lattice components, x lowest
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      la1[k] = IB'($signed(a1[k*CB +: CB]));
      la2[k] = IB'($signed(a2[k*CB +: CB]));
      la3[k] = IB'($signed(a3[k*CB +: CB]));
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_img
    // Digit 0 means no shift, 1 plus one vector, 2 minus one vector
    localparam int C1 = j / 9;
    localparam int C2 = (j / 3) % 3;
    localparam int C3 = j % 3;

    logic signed [IB-1:0] d    [3];
    logic        [IB-1:0] mag  [3];
    logic                 far;
    logic                 en;

    // Form the image offset and its magnitude
    always_comb begin
      far = 1'b0;
      for (int k = 0; k < 3; k++) begin
        d[k] = IB'(base[k]);
        if (C1 == 1) d[k] = d[k] + la1[k];
        if (C1 == 2) d[k] = d[k] - la1[k];
        if (C2 == 1) d[k] = d[k] + la2[k];
        if (C2 == 2) d[k] = d[k] - la2[k];
        if (C3 == 1) d[k] = d[k] + la3[k];
        if (C3 == 2) d[k] = d[k] - la3[k];
        mag[k] = d[k][IB-1] ? IB'(-d[k]) : IB'(d[k]);
        far    = far | (|mag[k][IB-1:OB]);
      end
      en = (C1 == 0 || dims >= 2'd1) && (C2 == 0 || dims >= 2'd2) &&
           (C3 == 0 || dims >= 2'd3);
    end

    always_ff @(posedge clk) begin
      for (int k = 0; k < 3; k++) ad[j][k] <= mag[k][OB-1:0];
      ok2[j] <= en & ~far;
    end

    // Square each component
    always_ff @(posedge clk) begin
      for (int k = 0; k < 3; k++) sq[j][k] <= ad[j][k] * ad[j][k];
      ok3[j] <= ok2[j];
    end

    // Sum the squares; drop images that are disabled or too far
    always_ff @(posedge clk) begin
      if (ok3[j]) begin
        keys[j] <= KB'(sq[j][0]) + KB'(sq[j][1]) + KB'(sq[j][2]);
      end else begin
        keys[j] <= '1;
      end
    end
  end

endmodule

### rtl/pmid_min.sv
// Registered minimum tree over the 27 image keys, three levels of three.
// Depends on pmid_pkg.
module pmid_min (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  pmid_pkg::key_t    keys [pmid_pkg::IMAGES],
  output pmid_pkg::keyreq_t best
);

  pmid_pkg::key_t l1 [9];
  pmid_pkg::key_t l2 [3];
  logic           v1, v2;

  function automatic pmid_pkg::key_t min3(input pmid_pkg::key_t a,
                                          input pmid_pkg::key_t b,
                                          input pmid_pkg::key_t c);
    pmid_pkg::key_t m;
    m = (b < a) ? b : a;
    m = (c < m) ? c : m;
    return m;
  endfunction

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      best.valid <= 1'b0;
    end else begin
      v1         <= in_valid;
      v2         <= v1;
      best.valid <= v2;
    end
  end

  // Reduce 27 to 9 to 3 to 1
  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) l1[i] <= min3(keys[3*i], keys[3*i+1], keys[3*i+2]);
    for (int i = 0; i < 3; i++) l2[i] <= min3(l1[3*i], l1[3*i+1], l1[3*i+2]);
    best.key <= min3(l2[0], l2[1], l2[2]);
  end

endmodule

### rtl/pmid_sqrt.sv
// Pipelined integer square root, one result bit per stage, with saturation.
// Depends on pmid_pkg.
module pmid_sqrt (
  input  logic              clk,
  input  logic              rst,
  input  pmid_pkg::keyreq_t req,
  output logic              done,
  output pmid_pkg::dist_t   distance
);

  localparam int RB = pmid_pkg::REM_BITS;
  localparam int S  = pmid_pkg::ROOT_STEPS;
  localparam int SB = pmid_pkg::SQ_BITS;

  logic [RB-1:0] rem [S+1];
  logic [RB-1:0] res [S+1];
  logic          sat [S+1];
  logic          vld [S+1];

  // Split the key into the value and the saturation flag
  always_comb begin
    rem[0] = RB'(req.key[SB-1:0]);
    res[0] = '0;
    sat[0] = |req.key[pmid_pkg::KEY_BITS-1:SB];
    vld[0] = req.valid;
  end

  for (genvar k = 0; k < S; k++) begin : g_step
    localparam logic [RB-1:0] BIT = RB'(1) << (2 * (S - 1 - k));
    logic [RB-1:0] trial;

    assign trial = res[k] + BIT;

    // Try one root bit
    always_ff @(posedge clk) begin
      if (rem[k] >= trial) begin
        rem[k+1] <= rem[k] - trial;
        res[k+1] <= (res[k] >> 1) + BIT;
      end else begin
        rem[k+1] <= rem[k];
        res[k+1] <= res[k] >> 1;
      end
      sat[k+1] <= sat[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end
  end

  // Hold the result for its strobe cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[S];
    end
  end

  always_ff @(posedge clk) begin
    distance <= sat[S] ? '1 : res[S][pmid_pkg::OUT_BITS-1:0];
  end

endmodule

### rtl/periodic_min_image_distance.sv
// Top level of the periodic minimum-image distance engine.
// Depends on pmid_pkg, pmid_image, pmid_min and pmid_sqrt.
//
// Usage:
//   Requests enter on start with the six coordinate ports; busy is always
//   low, so a new request is taken in every cycle that start is high.
//   Each request gives one result on distance, marked by done for one cycle;
//   results leave in request order. Throughput is one request per cycle: 27
//   images are evaluated in parallel (81 squarers), reduced by a three-level
//   registered minimum tree, and the root is taken by a 22-stage pipeline,
//   one root bit per stage.
//   The receiver cannot stall; done simply marks the cycle to capture.
//   Registers (APB, 64-bit data, byte address 8*i): 0 periodic_dims,
//   1 lattice_a1, 2 lattice_a2, 3 lattice_a3. Write them only while idle.
//   Reset clears all registers to zero and drops every request in flight.
//
module periodic_min_image_distance (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  pmid_pkg::coord_t         first_x,
  input  pmid_pkg::coord_t         first_y,
  input  pmid_pkg::coord_t         first_z,
  input  pmid_pkg::coord_t         second_x,
  input  pmid_pkg::coord_t         second_y,
  input  pmid_pkg::coord_t         second_z,
  output logic                     done,
  output pmid_pkg::dist_t          distance,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [4:0]               paddr,
  input  logic [63:0]              pwdata,
  output logic [63:0]              prdata,
  output logic                     pready
);

  logic [pmid_pkg::DIMS_BITS-1:0] periodic_dims;
  pmid_pkg::lat_t                 lattice_a1;
  pmid_pkg::lat_t                 lattice_a2;
  pmid_pkg::lat_t                 lattice_a3;
  logic                           keys_valid;
  pmid_pkg::key_t                 keys [pmid_pkg::IMAGES];
  pmid_pkg::keyreq_t              best;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      periodic_dims <= '0;
      lattice_a1    <= '0;
      lattice_a2    <= '0;
      lattice_a3    <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:3])
        pmid_pkg::REG_DIMS: periodic_dims <= pwdata[pmid_pkg::DIMS_BITS-1:0];
        pmid_pkg::REG_A1:   lattice_a1    <= pwdata[pmid_pkg::LAT_BITS-1:0];
        pmid_pkg::REG_A2:   lattice_a2    <= pwdata[pmid_pkg::LAT_BITS-1:0];
        pmid_pkg::REG_A3:   lattice_a3    <= pwdata[pmid_pkg::LAT_BITS-1:0];
        default:            ;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    case (paddr[4:3])
      pmid_pkg::REG_DIMS: prdata = 64'(periodic_dims);
      pmid_pkg::REG_A1:   prdata = 64'(lattice_a1);
      pmid_pkg::REG_A2:   prdata = 64'(lattice_a2);
      pmid_pkg::REG_A3:   prdata = 64'(lattice_a3);
      default:            prdata = '0;
    endcase
  end

  pmid_image u_image (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .first_x   (first_x),
    .first_y   (first_y),
    .first_z   (first_z),
    .second_x  (second_x),
    .second_y  (second_y),
    .second_z  (second_z),
    .dims      (periodic_dims),
    .a1        (lattice_a1),
    .a2        (lattice_a2),
    .a3        (lattice_a3),
    .out_valid (keys_valid),
    .keys      (keys)
  );

  pmid_min u_min (
    .clk      (clk),
    .rst      (rst),
    .in_valid (keys_valid),
    .keys     (keys),
    .best     (best)
  );

  pmid_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .req      (best),
    .done     (done),
    .distance (distance)
  );

endmodule
